// File: src/sit_pkg.sv
// shared constants and types of the segment intersection test
`default_nettype none

package sit_pkg;

  localparam int COORD_W     = 16;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int NUM_TESTS   = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
  } vec_t;

  // one orientation test: point relative to segment start (q) and end (r)
  typedef struct packed {
    vec_t q;
    vec_t r;
  } test_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic                        touch;
    vec_t                        dir_a;
    vec_t                        dir_b;
    test_t [NUM_TESTS-1:0]       test;
  } work_t;

  // products of one orientation test
  typedef struct packed {
    prod_t qx_dy;
    prod_t qy_dx;
    prod_t qx_dx;
    prod_t qy_dy;
    prod_t rx_dx;
    prod_t ry_dy;
  } prods_t;

endpackage

`default_nettype wire

// File: src/sit_if.sv
// item channels of the segment intersection test
`default_nettype none

interface sit_in_if import sit_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t a_start_x;
  coord_t a_start_y;
  coord_t a_end_x;
  coord_t a_end_y;
  coord_t b_start_x;
  coord_t b_start_y;
  coord_t b_end_x;
  coord_t b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

interface sit_out_if ();
  logic valid;
  logic ready;
  logic crossing;
  logic contiguous;

  modport source (output valid, crossing, contiguous, input ready);
  modport sink (input valid, crossing, contiguous, output ready);
endinterface

`default_nettype wire

// File: src/sit_front.sv
// front: accepts segment pairs, flags contiguous ones, forms difference vectors
`default_nettype none

module sit_front import sit_pkg::*; (
  sit_in_if.sink      in_i,
  output work_t       push_data_o,
  output logic        push_valid_o,
  input  logic        push_ready_i
);

  function automatic diff_t sub_f(coord_t a, coord_t b);
    diff_t ea;
    diff_t eb;
    ea = diff_t'(a);
    eb = diff_t'(b);
    return ea - eb;
  endfunction

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

  always_comb begin
    push_data_o.touch = ((in_i.a_start_x == in_i.b_end_x) && (in_i.a_start_y == in_i.b_end_y))
                     || ((in_i.a_end_x == in_i.b_start_x) && (in_i.a_end_y == in_i.b_start_y));

    push_data_o.dir_a.x = sub_f(in_i.a_end_x, in_i.a_start_x);
    push_data_o.dir_a.y = sub_f(in_i.a_end_y, in_i.a_start_y);
    push_data_o.dir_b.x = sub_f(in_i.b_end_x, in_i.b_start_x);
    push_data_o.dir_b.y = sub_f(in_i.b_end_y, in_i.b_start_y);

    // b start against segment a
    push_data_o.test[0].q.x = sub_f(in_i.b_start_x, in_i.a_start_x);
    push_data_o.test[0].q.y = sub_f(in_i.b_start_y, in_i.a_start_y);
    push_data_o.test[0].r.x = sub_f(in_i.b_start_x, in_i.a_end_x);
    push_data_o.test[0].r.y = sub_f(in_i.b_start_y, in_i.a_end_y);
    // b end against segment a
    push_data_o.test[1].q.x = sub_f(in_i.b_end_x, in_i.a_start_x);
    push_data_o.test[1].q.y = sub_f(in_i.b_end_y, in_i.a_start_y);
    push_data_o.test[1].r.x = sub_f(in_i.b_end_x, in_i.a_end_x);
    push_data_o.test[1].r.y = sub_f(in_i.b_end_y, in_i.a_end_y);
    // a start against segment b
    push_data_o.test[2].q.x = sub_f(in_i.a_start_x, in_i.b_start_x);
    push_data_o.test[2].q.y = sub_f(in_i.a_start_y, in_i.b_start_y);
    push_data_o.test[2].r.x = sub_f(in_i.a_start_x, in_i.b_end_x);
    push_data_o.test[2].r.y = sub_f(in_i.a_start_y, in_i.b_end_y);
    // a end against segment b
    push_data_o.test[3].q.x = sub_f(in_i.a_end_x, in_i.b_start_x);
    push_data_o.test[3].q.y = sub_f(in_i.a_end_y, in_i.b_start_y);
    push_data_o.test[3].r.x = sub_f(in_i.a_end_x, in_i.b_end_x);
    push_data_o.test[3].r.y = sub_f(in_i.a_end_y, in_i.b_end_y);
  end

endmodule

`default_nettype wire

// File: src/sit_queue.sv
// short queue of classified items between front and back
`default_nettype none

module sit_queue import sit_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  work_t push_data_i,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  output work_t pop_data_o,
  output logic  pop_valid_o,
  input  logic  pop_ready_i
);

  work_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/sit_back.sv
// back: products, orientation signs and the crossing decision
`default_nettype none

module sit_back import sit_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  work_t      pop_data_i,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  sit_out_if.source  out_o
);

  typedef struct packed {
    logic pos;
    logic neg;
  } orient_t;

  function automatic orient_t orient_f(prods_t p);
    sum_t    a;
    sum_t    b;
    sum_t    cr;
    sum_t    dt;
    sum_t    ed;
    orient_t o;
    a  = sum_t'(p.qx_dy);
    b  = sum_t'(p.qy_dx);
    cr = a - b;
    a  = sum_t'(p.qx_dx);
    b  = sum_t'(p.qy_dy);
    dt = a + b;
    a  = sum_t'(p.rx_dx);
    b  = sum_t'(p.ry_dy);
    ed = a + b;
    priority if (cr != '0) begin
      o.pos = !cr[SUM_W-1];
      o.neg = cr[SUM_W-1];
    end else if (dt[SUM_W-1]) begin
      // collinear, before the start
      o.pos = 1'b0;
      o.neg = 1'b1;
    end else if (dt == '0) begin
      o.pos = 1'b0;
      o.neg = 1'b0;
    end else begin
      // collinear past the start: beyond the end or on the segment
      o.pos = !ed[SUM_W-1] && (ed != '0);
      o.neg = 1'b0;
    end
    return o;
  endfunction

  prods_t [NUM_TESTS-1:0] prod_d, prod_q;
  orient_t [NUM_TESTS-1:0] orient;
  logic s1_valid_q;
  logic s1_touch_q;
  logic out_valid_q;
  logic crossing_q, crossing_d;
  logic contig_q;
  logic en;
  logic ok_a;
  logic ok_b;

  assign en          = !out_valid_q || out_o.ready;
  assign pop_ready_o = en;

  // stage one: six products per orientation test
  always_comb begin
    vec_t d;
    for (int i = 0; i < NUM_TESTS; i++) begin
      d = (i < NUM_TESTS / 2) ? pop_data_i.dir_a : pop_data_i.dir_b;
      prod_d[i].qx_dy = prod_t'(pop_data_i.test[i].q.x) * prod_t'(d.y);
      prod_d[i].qy_dx = prod_t'(pop_data_i.test[i].q.y) * prod_t'(d.x);
      prod_d[i].qx_dx = prod_t'(pop_data_i.test[i].q.x) * prod_t'(d.x);
      prod_d[i].qy_dy = prod_t'(pop_data_i.test[i].q.y) * prod_t'(d.y);
      prod_d[i].rx_dx = prod_t'(pop_data_i.test[i].r.x) * prod_t'(d.x);
      prod_d[i].ry_dy = prod_t'(pop_data_i.test[i].r.y) * prod_t'(d.y);
    end
  end

  // stage two: signs and pairing; a pair passes unless both share a nonzero sign
  always_comb begin
    for (int i = 0; i < NUM_TESTS; i++) begin
      orient[i] = orient_f(prod_q[i]);
    end
    ok_a = !((orient[0].pos && orient[1].pos) || (orient[0].neg && orient[1].neg));
    ok_b = !((orient[2].pos && orient[3].pos) || (orient[2].neg && orient[3].neg));
    crossing_d = !s1_touch_q && ok_a && ok_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= pop_valid_i;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q     <= prod_d;
      s1_touch_q <= pop_data_i.touch;
      crossing_q <= crossing_d;
      contig_q   <= s1_touch_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.crossing   = crossing_q;
  assign out_o.contiguous = contig_q;

endmodule

`default_nettype wire

// File: src/segment_intersection_test.sv
// top level of the segment intersection test
// usage:
// - in_i carries one segment pair per item: start and end points of segments
//   a and b as signed 16-bit coordinates; an item is taken when valid and ready
//   are both high at a rising clock edge
// - out_o returns one item per pair: crossing (segments meet) and contiguous
//   (a's start is b's end or a's end is b's start; crossing is then 0)
// - the front forms difference vectors and the contiguous flag and writes
//   them into a four-entry queue; the back pops one item per cycle while its
//   output is not stalled, forms the orientation products in one registered
//   stage, then the signs and the decision into the output register
// - an accepted item passes the queue, the product register and the output
//   register before its result is valid
// - throughput: one item per cycle when out_o is ready, set by the single product stage
// - receiver stall: the back pipeline holds, the queue fills, and in_i.ready
//   falls once four items wait; items are never dropped or repeated
// - reset (rst_ni low, asynchronous) empties the queue and clears all valid
//   flags; in_i.ready is high right after reset
`default_nettype none

module segment_intersection_test import sit_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sit_in_if.sink    in_i,
  sit_out_if.source out_o
);

  // front to queue
  work_t push_data;
  logic  push_valid;
  logic  push_ready;
  // queue to back
  work_t pop_data;
  logic  pop_valid;
  logic  pop_ready;

  sit_front u_front (
    .in_i         (in_i),
    .push_data_o  (push_data),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  sit_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_data),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  sit_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_data_i  (pop_data),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
